// ----- hw/rtl/iair_pkg.sv -----
// iair_pkg: shared types and constants for the indexed array insert/remove block
// holds operation and status codes, field widths, controller states and the
// command/status structs between controller and datapath; depends on nothing
package iair_pkg;

	// array size and dump limit
	localparam int Capacity   = 16;
	localparam int MaxResults = 16;

	// fixed field widths of the ports
	localparam int OpW     = 2;
	localparam int PosW    = 5;
	localparam int DataW   = 32;
	localparam int StatusW = 2;
	localparam int SlotW   = 4;
	localparam int CountW  = 5;

	// internal widths that follow the capacity
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);
	localparam int CmpW = ((PosW > CntW) ? PosW : CntW) + 1;

	// dump length limit as a count value
	localparam logic [CntW-1:0] DumpMax =
		(Capacity > MaxResults) ? CntW'(MaxResults) : CntW'(Capacity);

	typedef enum logic [OpW-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUICK  = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [StatusW-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_INDEX = 2'd1,
		STS_FULL      = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;       // run the accepted item and load its first result
		logic dump_next;  // load the next dump beat
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;   // output register holds a beat
		logic dump_more;  // dump being executed has more than one beat
		logic dump_final; // beat at the dump index is the final one
	} sts_t;

endpackage

// ----- hw/rtl/iair_ctrl.sv -----
// iair_ctrl: controller state machine for the indexed array block
// decides when an item is taken and steps dumps one beat at a time;
// depends on iair_pkg
module iair_ctrl import iair_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   can_load;

	// output register free now or freed at this edge
	assign can_load = !sts.out_full || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.exec      = 1'b0;
		cmd.dump_next = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = !can_load;
				cmd.exec = in_valid && can_load;
				if (cmd.exec && sts.dump_more) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				cmd.dump_next = can_load;
				if (can_load && sts.dump_final) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/iair_dp.sv -----
// iair_dp: datapath of the indexed array block
// holds the shifting cell array, entry count, dump index and output register;
// depends on iair_pkg
module iair_dp import iair_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [OpW-1:0]      operation,
	input  logic [PosW-1:0]     position,
	input  logic [DataW-1:0]    data_in,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [StatusW-1:0]  status,
	output logic [SlotW-1:0]    slot,
	output logic [DataW-1:0]    data_out,
	output logic [CountW-1:0]   count,
	output logic                last
);

	logic [DataW-1:0] cells_q [Capacity];
	logic [DataW-1:0] cells_d [Capacity];
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_d;
	logic [IdxW-1:0]  idx_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [IdxW-1:0]  out_slot_q;
	logic [DataW-1:0] out_data_q;
	logic [CntW-1:0]  out_count_q;
	logic             out_last_q;

	op_t              op;
	logic [CmpW-1:0]  pos_c;
	logic [CmpW-1:0]  cnt_c;
	logic [CntW-1:0]  cnt_m1;
	logic [CntW-1:0]  dump_len;
	logic [IdxW-1:0]  rd_addr;
	logic [DataW-1:0] rd_data;
	logic             bad_ins;
	logic             full;
	logic             bad_rem;

	status_t          res_status;
	logic [IdxW-1:0]  res_slot;
	logic [DataW-1:0] res_data;
	logic             res_last;
	logic             load;

	assign op       = op_t'(operation);
	assign pos_c    = CmpW'(position);
	assign cnt_c    = CmpW'(count_q);
	assign cnt_m1   = count_q - CntW'(1);
	assign dump_len = (count_q > DumpMax) ? DumpMax : count_q;

	assign bad_ins = pos_c > cnt_c;
	assign full    = count_q == CntW'(Capacity);
	assign bad_rem = pos_c >= cnt_c;

	// single read port: dump index while dumping, else entry 0 or the tail
	always_comb begin
		if (cmd.dump_next) begin
			rd_addr = idx_q;
		end else if (op == OP_DUMP) begin
			rd_addr = '0;
		end else begin
			rd_addr = cnt_m1[IdxW-1:0];
		end
	end
	assign rd_data = cells_q[rd_addr];

	// all cells move in parallel
	always_comb begin
		cells_d = cells_q;
		count_d = count_q;
		if (cmd.exec) begin
			case (op)
				OP_INSERT: begin
					if (!bad_ins && !full) begin
						for (int k = 0; k < Capacity; k++) begin
							if (CmpW'(k) == pos_c) begin
								cells_d[k] = data_in;
							end else if (k > 0 && CmpW'(k) > pos_c && CmpW'(k) <= cnt_c) begin
								cells_d[k] = cells_q[(k > 0) ? k - 1 : 0];
							end
						end
						count_d = count_q + CntW'(1);
					end
				end
				OP_REMOVE: begin
					if (!bad_rem) begin
						for (int k = 0; k < Capacity - 1; k++) begin
							if (CmpW'(k) >= pos_c && CmpW'(k + 1) < cnt_c) begin
								cells_d[k] = cells_q[k + 1];
							end
						end
						count_d = cnt_m1;
					end
				end
				OP_QUICK: begin
					if (!bad_rem) begin
						for (int k = 0; k < Capacity; k++) begin
							if (CmpW'(k) == pos_c) begin
								cells_d[k] = rd_data;
							end
						end
						count_d = cnt_m1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result of the item or dump beat being loaded
	always_comb begin
		res_status = STS_OK;
		res_slot   = '0;
		res_data   = '0;
		res_last   = 1'b1;
		if (cmd.dump_next) begin
			res_slot = idx_q;
			res_data = rd_data;
			res_last = sts.dump_final;
		end else begin
			case (op)
				OP_INSERT: begin
					if (bad_ins) begin
						res_status = STS_BAD_INDEX;
					end else if (full) begin
						res_status = STS_FULL;
					end
				end
				OP_REMOVE, OP_QUICK: begin
					if (bad_rem) begin
						res_status = STS_BAD_INDEX;
					end
				end
				OP_DUMP: begin
					if (count_q == '0) begin
						res_status = STS_EMPTY;
					end else begin
						res_data = rd_data;
						res_last = dump_len == CntW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.out_full   = out_valid_q;
	assign sts.dump_more  = (op == OP_DUMP) && (dump_len > CntW'(1));
	assign sts.dump_final = (CntW'(idx_q) + CntW'(1)) == dump_len;

	assign load = cmd.exec || cmd.dump_next;

	always_ff @(posedge clk) begin
		cells_q <= cells_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.exec) begin
				idx_q <= IdxW'(1);
			end else if (cmd.dump_next) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status;
			out_slot_q   <= res_slot;
			out_data_q   <= res_data;
			out_count_q  <= count_d;
			out_last_q   <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = SlotW'(out_slot_q);
	assign data_out  = out_data_q;
	assign count     = CountW'(out_count_q);
	assign last      = out_last_q;

endmodule

// ----- hw/rtl/indexed_array_insert_remove.sv -----
// indexed_array_insert_remove: top level of the ordered array with indexed
// insert, shift remove, quick remove and dump; joins iair_ctrl and iair_dp,
// depends on iair_pkg
//
//   channel   direction  handshake            beat contents
//   in        to block   in_valid / in_stall   operation, position, data_in
//   out       from block out_valid / out_stall status, slot, data_out, count, last
//
// insert and remove shift all cells together, quick remove moves the tail entry
// into the freed slot, and the single result beat is registered at the same edge
// a dump of n entries gives n beats (one STS_EMPTY beat if n is 0), one per cycle
// unless stalled, via the one cell read port; a new item waits for the final beat
// the output register frees the input side as soon as the held beat leaves
// a stalled out beat holds; the dump pauses while out_stall is high
// reset clears the count and control state at once; cells need no clearing
module indexed_array_insert_remove import iair_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OpW-1:0]     operation,
	input  logic [PosW-1:0]    position,
	input  logic [DataW-1:0]   data_in,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [StatusW-1:0] status,
	output logic [SlotW-1:0]   slot,
	output logic [DataW-1:0]   data_out,
	output logic [CountW-1:0]  count,
	output logic               last
);

	// command from controller, status back from datapath
	cmd_t cmd;
	sts_t sts;

	// state machine: idle or stepping a dump
	iair_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// cells, count, dump index and output register
	iair_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.position  (position),
		.data_in   (data_in),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.slot      (slot),
		.data_out  (data_out),
		.count     (count),
		.last      (last)
	);

endmodule

// ----- hw/rtl/iair_checker.sv -----
// iair_port_props: port-level assertions for indexed_array_insert_remove
// bound to the top level; depends on iair_pkg
module iair_port_props import iair_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [StatusW-1:0] status,
	input logic [SlotW-1:0]   slot,
	input logic [DataW-1:0]   data_out,
	input logic [CountW-1:0]  count,
	input logic               last
);

	// a held beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot)
			&& $stable(data_out) && $stable(count) && $stable(last))
		else $error("out beat changed while stalled");

	// no new item while a dump is still running
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("item taken in the middle of a dump");

	// error beats are single and carry no entry
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |-> last && slot == '0 && data_out == '0)
		else $error("error beat with entry data or not final");

	// count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CountW'(Capacity))
		else $error("count above capacity");

endmodule

bind indexed_array_insert_remove iair_port_props u_iair_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.slot      (slot),
	.data_out  (data_out),
	.count     (count),
	.last      (last)
);
